>>> rtl/core/tss_pkg.sv
`default_nettype none

package tss_pkg;

  // Sizes
  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int TIME_W              = 32;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 16;

  // Command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_REQUEST = 3'd1;
  localparam logic [2:0] CMD_ADJUST  = 3'd2;
  localparam logic [2:0] CMD_SCHED   = 3'd3;
  localparam logic [2:0] CMD_CANCEL  = 3'd4;
  localparam logic [2:0] CMD_HIT     = 3'd5;

  // Stick drive codes
  localparam logic [1:0] DRIVE_NONE    = 2'd0;
  localparam logic [1:0] DRIVE_STRIKE  = 2'd1;
  localparam logic [1:0] DRIVE_RETRACT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DRUM_ID  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE   = 2'd2;

  // Register reset values
  localparam logic [7:0]  DRUM_ID_RESET  = 8'd1;
  localparam logic [15:0] COOLDOWN_RESET = 16'd64;

  typedef struct packed {
    logic [2:0]        command;
    logic [7:0]        target_mask;
    logic [TIME_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic              reply_valid;
    logic [TIME_W-1:0] reply_clock;
    logic [7:0]        reply_id;
    logic [1:0]        drive_event;
    logic              strike_refused;
    logic [4:0]        queue_count;
  } result_t;

  // Queue operations requested by the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } qctl_t;

endpackage

`default_nettype wire

>>> rtl/core/timed_strike_scheduler.sv
// Sequencing: each item takes a read-then-compare walk over the registered-read
//   queue memory (S_CHECK_RD, S_CHECK_CMP), then S_FINISH registers its result; a
//   forward clock adjust first walks S_DRAIN_RD, S_DRAIN_CMP until no earlier time
//   is queued. Items enter only in S_IDLE, and S_FINISH holds on a stalled result.
// Reset (rst, synchronous): clock, release time and queue pointers go to zero, the
//   stick is ready and registers take their defaults; queue storage is not cleared.
`default_nettype none

module timed_strike_scheduler import tss_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire item_t                  item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN_RD,
    S_DRAIN_CMP,
    S_CHECK_RD,
    S_CHECK_CMP,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_READY     = 2'd0,
    PH_HIT       = 2'd1,
    PH_RETRACTED = 2'd2
  } phase_t;

  state_t            state;
  phase_t            phase;
  phase_t            phase_next;
  logic [TIME_W-1:0] vclock;
  logic [TIME_W-1:0] adj_clock;
  logic [TIME_W-1:0] adj_sum;
  logic [TIME_W-1:0] release_time;
  logic [TIME_W-1:0] release_next;
  logic [TIME_W-1:0] release_sum;
  logic              play;
  logic              reply;
  logic [7:0]        drum_id;
  logic [15:0]       cooldown;
  logic              single_mode;
  logic              addressed;
  logic              accept;
  logic              q_empty;
  logic              drain_pop;
  logic              check_pop;
  logic              out_free;
  logic [1:0]        drive;
  logic              refused;
  qctl_t             qctl;
  logic [TIME_W-1:0] q_head_time;
  logic [FILL_W-1:0] q_fill;

  // Configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      drum_id     <= DRUM_ID_RESET;
      cooldown    <= COOLDOWN_RESET;
      single_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRUM_ID:  drum_id     <= cfg_data[7:0];
        CFG_COOLDOWN: cooldown    <= cfg_data[15:0];
        CFG_SINGLE:   single_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Schedule queue
  tss_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (qctl),
    .push_time(item.value),
    .head_time(q_head_time),
    .fill     (q_fill)
  );

  // Decode and queue control
  assign item_ready = (state == S_IDLE) && !rst;
  assign accept     = item_valid && item_ready;
  assign addressed  = |(item.target_mask & drum_id);
  assign adj_sum    = vclock + item.value;
  assign q_empty    = (q_fill == '0);
  assign drain_pop  = (state == S_DRAIN_CMP) && !q_empty && (q_head_time < adj_clock);
  assign check_pop  = (state == S_CHECK_CMP) && !q_empty && (q_head_time == vclock);
  assign out_free   = !result_valid || result_ready;

  assign qctl.push  = accept && (item.command == CMD_SCHED) && addressed;
  assign qctl.clear = accept && (item.command == CMD_CANCEL);
  assign qctl.pop   = drain_pop || check_pop;

  // Cooldown, then strike
  assign release_sum = vclock + TIME_W'(cooldown);

  always_comb begin
    phase_next   = phase;
    release_next = release_time;
    drive        = DRIVE_NONE;
    refused      = 1'b0;
    if (vclock == release_time) begin
      case (phase)
        PH_READY: ;
        PH_HIT: begin
          if (single_mode) begin
            drive        = DRIVE_RETRACT;
            phase_next   = PH_RETRACTED;
            release_next = release_sum;
          end else begin
            phase_next = PH_READY;
          end
        end
        default: phase_next = PH_READY;
      endcase
    end
    if (play) begin
      if (phase_next == PH_READY) begin
        drive        = DRIVE_STRIKE;
        phase_next   = PH_HIT;
        release_next = release_sum;
      end else begin
        refused = 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_READY;
      vclock       <= '0;
      release_time <= '0;
      play         <= 1'b0;
      reply        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // drop an accepted result beat unless a new one replaces it
      if (result_valid && result_ready && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            play  <= (item.command == CMD_HIT) && addressed;
            reply <= (item.command == CMD_REQUEST);
            state <= S_CHECK_RD;
            case (item.command)
              CMD_TICK: vclock <= vclock + 1'b1;
              CMD_ADJUST: begin
                adj_clock <= adj_sum;
                if (adj_sum > vclock) begin
                  state <= S_DRAIN_RD;
                end else begin
                  vclock <= adj_sum;
                end
              end
              default: ;
            endcase
          end
        end
        S_DRAIN_RD: state <= S_DRAIN_CMP;
        S_DRAIN_CMP: begin
          // drop times left behind by a forward move, one per pass
          if (drain_pop) begin
            play  <= 1'b1;
            state <= S_DRAIN_RD;
          end else begin
            vclock <= adj_clock;
            state  <= S_CHECK_RD;
          end
        end
        S_CHECK_RD: state <= S_CHECK_CMP;
        S_CHECK_CMP: begin
          if (check_pop) begin
            play <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            phase                 <= phase_next;
            release_time          <= release_next;
            result_valid          <= 1'b1;
            result.reply_valid    <= reply;
            result.reply_clock    <= vclock;
            result.reply_id       <= drum_id;
            result.drive_event    <= drive;
            result.strike_refused <= refused;
            result.queue_count    <= 5'(q_fill);
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tss_queue.sv
`default_nettype none

module tss_queue import tss_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qctl_t             ctl,
  input  wire logic [TIME_W-1:0] push_time,
  output logic      [TIME_W-1:0] head_time,
  output logic      [FILL_W-1:0] fill
);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic              do_push;
  logic              do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // Drop pushes when full and pops when empty
  assign do_push = ctl.push && (fill != FILL_W'(DEPTH));
  assign do_pop  = ctl.pop && (fill != '0);

  // Storage: one write port, head read registered
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_time;
    end
    head_time <= mem[head];
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= ptr_inc(tail);
      end
      if (do_pop) begin
        head <= ptr_inc(head);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tss_checker.sv
`default_nettype none

module tss_checker import tss_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   item_valid,
  input wire logic                   item_ready,
  input wire item_t                  item,
  input wire logic                   result_valid,
  input wire logic                   result_ready,
  input wire result_t                result,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [CFG_INDEX_W-1:0] cfg_index,
  input wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // One item at a time: no new beat right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after an accepted beat");

  // A refused strike never drives a strike, and no drive code beyond retract
  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.drive_event != 2'd3) &&
                     !(result.strike_refused && (result.drive_event == DRIVE_STRIKE)))
    else $error("inconsistent drive event");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind timed_strike_scheduler tss_checker u_tss_checker (.*);

`default_nettype wire
